>>> hdl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length scanline decoder.
package pcxrle_pkg;

    // Field widths of the stream and of the decoder state.
    localparam int BYTE_W   = 8;
    localparam int PLANE_W  = 2;
    localparam int COL_W    = 16;
    localparam int LINE_W   = 16;
    localparam int COUNT_W  = 6;
    localparam int PLCFG_W  = 3;
    localparam int LNCFG_W  = 17;
    localparam int CFG_W    = 17;
    localparam int IDX_W    = 2;

    // Result word: pixel, plane, column, line, line end, image end, zero pad.
    localparam int TDATA_RAW_W = BYTE_W + PLANE_W + COL_W + LINE_W + 2;
    localparam int TDATA_W     = ((TDATA_RAW_W + 7) / 8) * 8;
    localparam int PAD_W       = TDATA_W - TDATA_RAW_W;

    // Default number of colour planes supported.
    localparam int MAX_PLANES_DEF = 4;

    // Top two bits of a run header.
    localparam logic [1:0] HDR_TAG = 2'b11;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_BPL    = 2'd0;
    localparam logic [IDX_W-1:0] REG_PLANES = 2'd1;
    localparam logic [IDX_W-1:0] REG_LINES  = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VALUE,
        ST_RUN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_count;
        logic load_value;
        logic emit_lit;
        logic emit_run;
        logic emit_bad;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_header;
        logic count_zero;
        logic slot_free;
        logic run_last;
    } status_t;

endpackage

>>> hdl/pcxrle_ctrl.sv
// Controller state machine of the PCX run-length decoder.
module pcxrle_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pcxrle_pkg::status_t status,
    output pcxrle_pkg::cmd_t    cmd,
    output pcxrle_pkg::state_t  state
);
    import pcxrle_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Input is taken while no run is expanding and the output slot is free.
    assign s_tready = ((state_reg == ST_IDLE) || (state_reg == ST_VALUE)) && status.slot_free;
    assign accept   = s_tvalid && s_tready;
    assign state    = state_reg;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && status.is_header && !status.count_zero) begin
                    state_next = ST_VALUE;
                end
            end
            ST_VALUE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.slot_free && status.run_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!status.is_header) begin
                        cmd.emit_lit = 1'b1;
                    end else if (status.count_zero) begin
                        cmd.emit_bad = 1'b1;
                    end else begin
                        cmd.load_count = 1'b1;
                    end
                end
            end
            ST_VALUE: begin
                cmd.load_value = accept;
            end
            ST_RUN: begin
                cmd.emit_run = status.slot_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/pcxrle_datapath.sv
// Datapath of the PCX run-length decoder: configuration, position and output register.
module pcxrle_datapath #(
    parameter int MAX_PLANES = pcxrle_pkg::MAX_PLANES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pcxrle_pkg::IDX_W-1:0]    cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [pcxrle_pkg::BYTE_W-1:0]   coded_byte,
    input  pcxrle_pkg::cmd_t                cmd,
    output pcxrle_pkg::status_t             status,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [pcxrle_pkg::TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import pcxrle_pkg::*;

    localparam logic [PLCFG_W-1:0] MaxPl = PLCFG_W'(MAX_PLANES);
    localparam logic [LNCFG_W-1:0] MaxLn = LNCFG_W'(1 << LINE_W);

    // Configuration registers.
    logic [COL_W-1:0]   bpl_reg;
    logic [PLCFG_W-1:0] planes_reg;
    logic [LNCFG_W-1:0] lines_reg;

    // Decoder state.
    logic [COUNT_W-1:0] count_reg;
    logic [BYTE_W-1:0]  value_reg;
    logic [PLANE_W-1:0] plane_reg;
    logic [COL_W-1:0]   col_reg;
    logic [LINE_W-1:0]  line_reg;

    // Output register.
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_pixel_reg;
    logic [PLANE_W-1:0] out_plane_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [LINE_W-1:0]  out_line_reg;
    logic               out_run_end_reg;
    logic               out_line_end_reg;
    logic               out_image_end_reg;
    logic               out_bad_reg;

    logic [COL_W-1:0]   eff_bpl;
    logic [PLCFG_W-1:0] eff_planes;
    logic [LNCFG_W-1:0] eff_lines;
    logic               col_last;
    logic               pl_last;
    logic               ln_last;
    logic               emit;
    logic               emit_last;
    logic [BYTE_W-1:0]  emit_value;

    // Effective limits with out-of-range register values clamped.
    always_comb begin
        eff_bpl = (bpl_reg == '0) ? COL_W'(1) : bpl_reg;
        if (planes_reg == '0) begin
            eff_planes = PLCFG_W'(1);
        end else if (planes_reg > MaxPl) begin
            eff_planes = MaxPl;
        end else begin
            eff_planes = planes_reg;
        end
        if (lines_reg == '0) begin
            eff_lines = LNCFG_W'(1);
        end else if (lines_reg > MaxLn) begin
            eff_lines = MaxLn;
        end else begin
            eff_lines = lines_reg;
        end
    end

    // End-of-line, end-of-plane and end-of-image tests on the current position.
    assign col_last = ({1'b0, col_reg} + (COL_W+1)'(1)) >= {1'b0, eff_bpl};
    assign pl_last  = ({1'b0, plane_reg} + PLCFG_W'(1)) >= eff_planes;
    assign ln_last  = ({1'b0, line_reg} + LNCFG_W'(1)) >= eff_lines;

    // A run byte is the last of its run when the count runs out or the plane line ends.
    assign status.is_header  = (coded_byte[BYTE_W-1 -: 2] == HDR_TAG);
    assign status.count_zero = (coded_byte[COUNT_W-1:0] == '0);
    assign status.slot_free  = !out_valid_reg || m_tready;
    assign status.run_last   = (count_reg == COUNT_W'(1)) || col_last;

    assign emit       = cmd.emit_lit || cmd.emit_run;
    assign emit_last  = cmd.emit_lit || status.run_last;
    assign emit_value = cmd.emit_lit ? coded_byte : value_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpl_reg    <= COL_W'(1);
            planes_reg <= PLCFG_W'(1);
            lines_reg  <= LNCFG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BPL:    bpl_reg    <= cfg_wdata[COL_W-1:0];
                REG_PLANES: planes_reg <= cfg_wdata[PLCFG_W-1:0];
                REG_LINES:  lines_reg  <= cfg_wdata[LNCFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // Run count and run value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.load_count) begin
            count_reg <= coded_byte[COUNT_W-1:0];
        end else if (cmd.emit_run) begin
            count_reg <= count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_value) begin
            value_reg <= coded_byte;
        end
    end

    // Position: column, then plane, then line; a bad header restarts the scanline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
            col_reg   <= '0;
            line_reg  <= '0;
        end else if (cmd.emit_bad) begin
            plane_reg <= '0;
            col_reg   <= '0;
        end else if (emit) begin
            if (!col_last) begin
                col_reg <= col_reg + COL_W'(1);
            end else begin
                col_reg <= '0;
                if (!pl_last) begin
                    plane_reg <= plane_reg + PLANE_W'(1);
                end else begin
                    plane_reg <= '0;
                    line_reg  <= ln_last ? '0 : line_reg + LINE_W'(1);
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit || cmd.emit_bad) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.emit_bad) begin
            out_pixel_reg     <= '0;
            out_plane_reg     <= '0;
            out_col_reg       <= '0;
            out_line_reg      <= '0;
            out_run_end_reg   <= 1'b0;
            out_line_end_reg  <= 1'b0;
            out_image_end_reg <= 1'b0;
            out_bad_reg       <= 1'b1;
        end else if (emit) begin
            out_pixel_reg     <= emit_value;
            out_plane_reg     <= plane_reg;
            out_col_reg       <= col_reg;
            out_line_reg      <= line_reg;
            out_run_end_reg   <= emit_last;
            out_line_end_reg  <= col_last && pl_last;
            out_image_end_reg <= col_last && pl_last && ln_last;
            out_bad_reg       <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_image_end_reg, out_line_end_reg, out_line_reg,
                       out_col_reg, out_plane_reg, out_pixel_reg};
    assign m_tlast  = out_run_end_reg;
    assign m_tuser  = out_bad_reg;

endmodule

>>> hdl/pcx_rle_scanline_decoder_unit.sv
// A literal or a zero-count header gives its result in the cycle after its transaction.
// A nonzero header gives no result; the registered value byte after it yields a run of n bytes
// (n up to 63, fewer at a plane line end) at one per cycle while the output slot is free.
// Throughput: one literal per cycle while the output slot is free; a run holds off input.
// Reset (aresetn low, synchronous) clears position, pending header and output valid,
// and sets every configuration register to 1.
module pcx_rle_scanline_decoder_unit #(
    parameter int MAX_PLANES = pcxrle_pkg::MAX_PLANES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [pcxrle_pkg::IDX_W-1:0]    cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]    cfg_wdata,
    // Compressed byte stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcxrle_pkg::BYTE_W-1:0]   s_tdata,   // coded_byte
    // Decoded byte stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_byte[7:0], plane_index[9:8], column_index[25:10], line_index[41:26],
    // line_end[42], image_end[43], zero pad[47:44]
    output logic [pcxrle_pkg::TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,   // run_end
    output logic                            m_tuser    // bad_header
);
    import pcxrle_pkg::*;

    cmd_t    cmd;
    status_t status;
    state_t  state;

    // Controller.
    pcxrle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    // Datapath.
    pcxrle_datapath #(
        .MAX_PLANES (MAX_PLANES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .coded_byte (s_tdata),
        .cmd        (cmd),
        .status     (status),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // No input is taken while a run is expanding.
    a_no_input_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_RUN) |-> !s_tready)
        else $error("input accepted during run expansion");

    // The last byte of a run returns the controller to idle.
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_run && status.run_last) |=> (state == ST_IDLE))
        else $error("run did not end on its last byte");

    // A bad-header result carries nothing else.
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata == '0) && !m_tlast))
        else $error("bad header result carries data");

    // The image end falls on a scanline end.
    a_image_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[43]) |-> m_tdata[42])
        else $error("image end without line end");

endmodule
